### rtl/core/pptt_pkg.sv
// Shared types and constants for the push-pull PWM / triac timer.
// Used by the channel interfaces, the step logic and the top level.
package pptt_pkg;

  localparam int ACTION_W   = 3;
  localparam int LEVEL_W    = 10;
  localparam int DUTY_W     = 8;
  localparam int PERIOD_W   = 8;
  localparam int CHARGE_W   = 8;
  localparam int PHASE_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam int CROSSINGS_PER_LATCH_DEF = 4;
  localparam int COUNT_WIDTH_DEF         = 8;

  // Action codes.
  localparam logic [ACTION_W-1:0] ACT_TICK     = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_CROSSING = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_FEEDBACK = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_START    = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_STOP     = 3'd4;

  // Drive phase codes. Code 3 is unused but counts like an armed drive.
  localparam logic [PHASE_W-1:0] PHASE_OFF      = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_ONE_NEXT = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_TWO_NEXT = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MAINS_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_COUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FB_TARGET     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_FLOOR    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_CEILING  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_CHARGE   = 3'd5;

  // Reset values.
  localparam logic [PERIOD_W-1:0] PERIOD_RST      = 8'd50;
  localparam logic [LEVEL_W-1:0]  FB_TARGET_RST   = 10'd48;
  localparam logic [DUTY_W-1:0]   DUTY_FLOOR_RST  = 8'd30;
  localparam logic [DUTY_W-1:0]   DUTY_CEIL_RST   = 8'd47;
  localparam logic [CHARGE_W-1:0] INIT_CHARGE_RST = 8'd40;
  localparam logic [DUTY_W-1:0]   DUTY_RST        = 8'd30;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [LEVEL_W-1:0]  feedback_level;
    logic [CHARGE_W-1:0] firing_point;
    logic                charge_allowed;
  } item_t;

  typedef struct packed {
    logic                gate_one;
    logic                gate_two;
    logic                triac_gate;
    logic [DUTY_W-1:0]   duty_pending;
  } result_t;

  typedef struct packed {
    logic                mains_mode;
    logic [PERIOD_W-1:0] period_count;
    logic [LEVEL_W-1:0]  feedback_target;
    logic [DUTY_W-1:0]   duty_floor;
    logic [DUTY_W-1:0]   duty_ceiling;
  } cfg_t;

endpackage

### rtl/core/pptt_if.sv
// Valid/ready channel interfaces for timer items and gate results.
// Depends on pptt_pkg for field widths.
interface pptt_item_if;
  logic                          valid;
  logic                          ready;
  logic [pptt_pkg::ACTION_W-1:0] action;
  logic [pptt_pkg::LEVEL_W-1:0]  feedback_level;
  logic [pptt_pkg::CHARGE_W-1:0] firing_point;
  logic                          charge_allowed;

  modport source (output valid, action, feedback_level, firing_point, charge_allowed,
                  input ready);
  modport sink   (input valid, action, feedback_level, firing_point, charge_allowed,
                  output ready);
endinterface

interface pptt_result_if;
  logic                        valid;
  logic                        ready;
  logic                        gate_one;
  logic                        gate_two;
  logic                        triac_gate;
  logic [pptt_pkg::DUTY_W-1:0] duty_pending;

  modport source (output valid, gate_one, gate_two, triac_gate, duty_pending,
                  input ready);
  modport sink   (input valid, gate_one, gate_two, triac_gate, duty_pending,
                  output ready);
endinterface

### rtl/core/push_pull_pwm_triac_timer.sv
// Top level of the push-pull PWM / triac timer: configuration registers,
// input register and result register around pptt_step. Depends on pptt_pkg, pptt_if.
//
// Usage:
//   The item channel carries timer events (tick, zero crossing, feedback
//   sample, start, stop) with their sample fields. Each transfer on it yields
//   exactly one transfer on the result channel, which reports the gate levels
//   and the pending duty as they stand after that event.
//   An item is captured in the input register. While it is held there,
//   pptt_step works it out, and its result lands in the result register.
//   The block sustains one item per clock while the receiver does not stall:
//   the input register refills in the same cycle that its item moves on to
//   the result register.
//   When the receiver stalls, the result register holds its value, the input
//   register holds the next item, and item ready drops once both are full.
//   Configuration is a plain write port (cfg_write, cfg_index, cfg_data). The
//   user must write it only while no item is in flight; the block does not
//   enforce it. Writing the initial charge point reloads the live charge point.
//   Reset (rst, synchronous, active high) empties both registers, turns the
//   drive off with all gates low, and restores each config register to its default.
module push_pull_pwm_triac_timer #(
  parameter int CROSSINGS_PER_LATCH = pptt_pkg::CROSSINGS_PER_LATCH_DEF,
  parameter int COUNT_WIDTH         = pptt_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [pptt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pptt_pkg::CFG_DATA_W-1:0] cfg_data,
  pptt_item_if.sink                       item,
  pptt_result_if.source                   result
);

  pptt_pkg::cfg_t    cfg;
  pptt_pkg::item_t   held_item;
  pptt_pkg::result_t step_result;
  pptt_pkg::result_t res;
  logic              held_valid;
  logic              res_valid;
  logic              advance;
  logic              step_en;
  logic              charge_load;

  // The result register may take a new value when it is empty or being drained.
  assign advance     = !res_valid || result.ready;
  assign step_en     = held_valid && advance;
  assign item.ready  = !held_valid || advance;
  assign charge_load = cfg_write && (cfg_index == pptt_pkg::REG_INIT_CHARGE);

  // Configuration registers. Indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mains_mode      <= 1'b0;
      cfg.period_count    <= pptt_pkg::PERIOD_RST;
      cfg.feedback_target <= pptt_pkg::FB_TARGET_RST;
      cfg.duty_floor      <= pptt_pkg::DUTY_FLOOR_RST;
      cfg.duty_ceiling    <= pptt_pkg::DUTY_CEIL_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        pptt_pkg::REG_MAINS_MODE:   cfg.mains_mode      <= cfg_data[0];
        pptt_pkg::REG_PERIOD_COUNT: cfg.period_count    <= cfg_data[pptt_pkg::PERIOD_W-1:0];
        pptt_pkg::REG_FB_TARGET:    cfg.feedback_target <= cfg_data[pptt_pkg::LEVEL_W-1:0];
        pptt_pkg::REG_DUTY_FLOOR:   cfg.duty_floor      <= cfg_data[pptt_pkg::DUTY_W-1:0];
        pptt_pkg::REG_DUTY_CEILING: cfg.duty_ceiling    <= cfg_data[pptt_pkg::DUTY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input register: captures an item whenever the slot is free or moving on.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item.ready) begin
      held_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      held_item.action         <= item.action;
      held_item.feedback_level <= item.feedback_level;
      held_item.firing_point   <= item.firing_point;
      held_item.charge_allowed <= item.charge_allowed;
    end
  end

  pptt_step #(
    .CROSSINGS_PER_LATCH (CROSSINGS_PER_LATCH),
    .COUNT_WIDTH         (COUNT_WIDTH)
  ) u_step (
    .clk          (clk),
    .rst          (rst),
    .step_en      (step_en),
    .item         (held_item),
    .cfg          (cfg),
    .charge_load  (charge_load),
    .charge_value (cfg_data[pptt_pkg::CHARGE_W-1:0]),
    .result       (step_result)
  );

  // Result register: loads the outcome of the item being processed.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      res <= step_result;
    end
  end

  assign result.valid        = res_valid;
  assign result.gate_one     = res.gate_one;
  assign result.gate_two     = res.gate_two;
  assign result.triac_gate   = res.triac_gate;
  assign result.duty_pending = res.duty_pending;

endmodule

### rtl/core/pptt_step.sv
// Drive state and the per-item update: PWM counter, triac phase counter,
// crossing counter and duty regulation. Depends on pptt_pkg.
module pptt_step #(
  parameter int CROSSINGS_PER_LATCH = pptt_pkg::CROSSINGS_PER_LATCH_DEF,
  parameter int COUNT_WIDTH         = pptt_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step_en,
  input  pptt_pkg::item_t               item,
  input  pptt_pkg::cfg_t                cfg,
  input  logic                          charge_load,
  input  logic [pptt_pkg::CHARGE_W-1:0] charge_value,
  output pptt_pkg::result_t             result
);

  localparam int XW    = (CROSSINGS_PER_LATCH > 1) ? $clog2(CROSSINGS_PER_LATCH) : 1;
  localparam int CMP_W = (COUNT_WIDTH > 8) ? COUNT_WIDTH : 8;
  localparam logic [XW-1:0] X_LAST = XW'(CROSSINGS_PER_LATCH - 1);

  logic [pptt_pkg::PHASE_W-1:0]  drive_phase, drive_phase_next;
  logic [pptt_pkg::DUTY_W-1:0]   duty_active, duty_active_next;
  logic [pptt_pkg::DUTY_W-1:0]   duty_request, duty_request_next;
  logic [COUNT_WIDTH-1:0]        pwm_count, pwm_count_next;
  logic [COUNT_WIDTH-1:0]        phase_count, phase_count_next;
  logic [XW-1:0]                 crossing_count, crossing_count_next;
  logic [pptt_pkg::CHARGE_W-1:0] charge_point, charge_point_next;
  logic                          gate_one, gate_one_next;
  logic                          gate_two, gate_two_next;
  logic                          triac, triac_next;

  logic [COUNT_WIDTH-1:0] pwm_inc;
  logic [COUNT_WIDTH-1:0] phase_inc;
  logic [CMP_W-1:0]       pwm_ext, phase_ext;
  logic [pptt_pkg::LEVEL_W:0] target_hi;

  assign pwm_inc   = pwm_count + 1'b1;
  assign phase_inc = phase_count + 1'b1;
  assign pwm_ext   = CMP_W'(pwm_inc);
  assign phase_ext = CMP_W'(phase_inc);
  assign target_hi = {1'b0, cfg.feedback_target} + 1'b1;

  always_comb begin
    drive_phase_next    = drive_phase;
    duty_active_next    = duty_active;
    duty_request_next   = duty_request;
    pwm_count_next      = pwm_count;
    phase_count_next    = phase_count;
    crossing_count_next = crossing_count;
    charge_point_next   = charge_point;
    gate_one_next       = gate_one;
    gate_two_next       = gate_two;
    triac_next          = triac;

    case (item.action)
      pptt_pkg::ACT_TICK: begin
        if (!cfg.mains_mode) begin
          triac_next = 1'b0;
          if (drive_phase == pptt_pkg::PHASE_OFF) begin
            gate_one_next = 1'b0;
            gate_two_next = 1'b0;
          end else begin
            if (drive_phase == pptt_pkg::PHASE_ONE_NEXT) begin
              duty_active_next = duty_request;
            end
            pwm_count_next = pwm_inc;
            if (pwm_ext == CMP_W'(duty_active_next)) begin
              gate_one_next = 1'b0;
              gate_two_next = 1'b0;
            end
            if (pwm_ext == CMP_W'(cfg.period_count)) begin
              pwm_count_next = '0;
              if (drive_phase == pptt_pkg::PHASE_ONE_NEXT) begin
                gate_one_next    = 1'b1;
                gate_two_next    = 1'b0;
                drive_phase_next = pptt_pkg::PHASE_TWO_NEXT;
              end else if (drive_phase == pptt_pkg::PHASE_TWO_NEXT) begin
                gate_one_next    = 1'b0;
                gate_two_next    = 1'b1;
                drive_phase_next = pptt_pkg::PHASE_ONE_NEXT;
              end
            end
          end
        end else begin
          gate_one_next    = 1'b0;
          gate_two_next    = 1'b0;
          phase_count_next = phase_inc;
          triac_next       = (phase_ext == CMP_W'(charge_point)) && item.charge_allowed;
        end
      end
      pptt_pkg::ACT_CROSSING: begin
        phase_count_next = '0;
        if (crossing_count == X_LAST) begin
          crossing_count_next = '0;
          charge_point_next   = item.firing_point;
        end else begin
          crossing_count_next = crossing_count + 1'b1;
        end
      end
      pptt_pkg::ACT_FEEDBACK: begin
        if (item.feedback_level < cfg.feedback_target) begin
          if (duty_request < cfg.duty_ceiling) begin
            duty_request_next = duty_request + 1'b1;
          end
        end else if ({1'b0, item.feedback_level} > target_hi) begin
          if (duty_request > cfg.duty_floor) begin
            duty_request_next = duty_request - 1'b1;
          end
        end
      end
      pptt_pkg::ACT_START: begin
        drive_phase_next  = pptt_pkg::PHASE_ONE_NEXT;
        duty_request_next = cfg.duty_floor;
        duty_active_next  = cfg.duty_floor;
        triac_next        = 1'b0;
      end
      pptt_pkg::ACT_STOP: begin
        drive_phase_next = pptt_pkg::PHASE_OFF;
        gate_one_next    = 1'b0;
        gate_two_next    = 1'b0;
        triac_next       = 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign result.gate_one     = gate_one_next;
  assign result.gate_two     = gate_two_next;
  assign result.triac_gate   = triac_next;
  assign result.duty_pending = duty_request_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_phase    <= pptt_pkg::PHASE_OFF;
      duty_active    <= pptt_pkg::DUTY_RST;
      duty_request   <= pptt_pkg::DUTY_RST;
      pwm_count      <= '0;
      phase_count    <= '0;
      crossing_count <= '0;
      charge_point   <= pptt_pkg::INIT_CHARGE_RST;
      gate_one       <= 1'b0;
      gate_two       <= 1'b0;
      triac          <= 1'b0;
    end else begin
      if (step_en) begin
        drive_phase    <= drive_phase_next;
        duty_active    <= duty_active_next;
        duty_request   <= duty_request_next;
        pwm_count      <= pwm_count_next;
        phase_count    <= phase_count_next;
        crossing_count <= crossing_count_next;
        charge_point   <= charge_point_next;
        gate_one       <= gate_one_next;
        gate_two       <= gate_two_next;
        triac          <= triac_next;
      end
      if (charge_load) begin
        charge_point <= charge_value;
      end
    end
  end

endmodule
